// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by matrix3x3_inverse.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMPLIES(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion lbl failed");

// next-cycle implication, disabled during reset
`define AST_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion lbl failed");

`endif

// ===== hw/rtl/mi3_pkg.sv =====
// types and constants of the 3x3 matrix inverse pipeline
package mi3_pkg;

  localparam int NENT    = 9;   // matrix entries
  localparam int ENT_W   = 16;  // Q8.8 entry
  localparam int PROD_W  = 32;  // entry times entry
  localparam int COF_W   = 33;  // cofactor, Q17.16
  localparam int DPROD_W = 49;  // entry times cofactor
  localparam int DET_W   = 50;  // determinant, Q26.24
  localparam int CMAG_W  = 32;  // cofactor magnitude
  localparam int QBITS   = 32;  // quotient bits resolved by the divider
  localparam int LOW_W   = 32;  // numerator bits shifted in by the divider
  localparam int OUT_W   = 32;  // Q16.16 result

  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic signed [DPROD_W-1:0] dprod_t;
  typedef logic signed [DET_W-1:0] det_t;
  typedef logic [CMAG_W-1:0] cmag_t;
  typedef logic [DET_W-1:0] dmag_t;
  typedef logic [QBITS-1:0] quo_t;
  typedef logic [LOW_W-1:0] low_t;

  // cofactor k = a[CF_IDX[k][0]]*a[CF_IDX[k][1]] - a[CF_IDX[k][2]]*a[CF_IDX[k][3]]
  // k is the transposed position, i.e. the inverse entry it feeds
  localparam int CF_IDX [NENT][4] = '{
    '{4, 8, 5, 7}, '{7, 2, 8, 1}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{8, 0, 6, 2}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{6, 1, 7, 0}, '{0, 4, 1, 3}
  };

  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// ===== hw/rtl/matrix3x3_inverse.sv =====
// throughput: one matrix per cycle while the output is not stalled; products,
//   cofactors, determinant and a 32-stage restoring divider (one quotient bit
//   per stage, nine lanes) all pipeline
// a stall at the output freezes the whole pipeline; nothing is lost or repeated
// reset clears only the stage valid bits; payload registers are not reset
module matrix3x3_inverse (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22 (16 bits each, lowest first)
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20, inv_21, inv_22 (32 bits each)
  output logic [287:0] out_tdata,
  // singular
  output logic [0:0]   out_tuser
);
  import mi3_pkg::*;
  `include "assert_macros.svh"

  logic ce;

  // stage valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic vd_r [QBITS];
  logic vo_r;

  // payload registers
  ent_t   a_r    [NENT];
  prod_t  p_r    [2*NENT];
  ent_t   r0_2_r [3];
  cof_t   cof3_r [NENT];
  ent_t   r0_3_r [3];
  dprod_t dp_r   [3];
  cof_t   cof4_r [NENT];
  det_t   det_r;
  cof_t   cof5_r [NENT];
  cmag_t  cmag_r [NENT];
  logic   csgn_r [NENT];
  dmag_t  dmag6_r;
  logic   dsgn6_r;
  logic   dzero6_r;

  // divider lanes, index 0 is the entry stage
  logic   neg_r  [QBITS+1][NENT];
  logic   ovf_r  [QBITS+1][NENT];
  dmag_t  rem_r  [QBITS+1][NENT];
  low_t   low_r  [QBITS+1][NENT];
  quo_t   quo_r  [QBITS+1][NENT];
  dmag_t  dmag_r [QBITS+1];
  logic   sing_r [QBITS+1];

  logic [287:0] odata_r;
  logic         osing_r;

  // whole pipeline advances unless the output holds an untaken item
  assign ce        = !vo_r || out_tready;
  assign in_tready = ce;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; vo_r <= 1'b0;
      for (int s = 0; s < QBITS; s++) vd_r[s] <= 1'b0;
    end else if (ce) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      vd_r[0] <= v7_r;
      for (int s = 1; s < QBITS; s++) vd_r[s] <= vd_r[s-1];
      vo_r <= vd_r[QBITS-1];
    end
  end

  // stages 1 to 6: entries, products, cofactors, determinant, magnitudes
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NENT; k++) a_r[k] <= ent_t'(in_tdata[ENT_W*k +: ENT_W]);
      for (int k = 0; k < NENT; k++) begin
        p_r[2*k]   <= a_r[CF_IDX[k][0]] * a_r[CF_IDX[k][1]];
        p_r[2*k+1] <= a_r[CF_IDX[k][2]] * a_r[CF_IDX[k][3]];
      end
      for (int j = 0; j < 3; j++) r0_2_r[j] <= a_r[j];
      for (int k = 0; k < NENT; k++)
        cof3_r[k] <= cof_t'(p_r[2*k]) - cof_t'(p_r[2*k+1]);
      for (int j = 0; j < 3; j++) r0_3_r[j] <= r0_2_r[j];
      // first-row expansion uses the cofactors of row 0, i.e. inverse entries 0, 3, 6
      for (int j = 0; j < 3; j++) dp_r[j] <= dprod_t'(r0_3_r[j]) * dprod_t'(cof3_r[3*j]);
      cof4_r <= cof3_r;
      det_r  <= det_t'(dp_r[0]) + det_t'(dp_r[1]) + det_t'(dp_r[2]);
      cof5_r <= cof4_r;
      for (int k = 0; k < NENT; k++) begin
        csgn_r[k] <= cof5_r[k][COF_W-1];
        cmag_r[k] <= cmag_t'(cof5_r[k][COF_W-1] ? -cof5_r[k] : cof5_r[k]);
      end
      dsgn6_r  <= det_r[DET_W-1];
      dmag6_r  <= dmag_t'(det_r[DET_W-1] ? -det_r : det_r);
      dzero6_r <= (det_r == '0);
    end
  end

  // stage 7: overflow check on the high numerator part and divider entry
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NENT; k++) begin
        ovf_r[0][k] <= dmag_t'(cmag_r[k][CMAG_W-1:8]) >= dmag6_r;
        rem_r[0][k] <= dmag_t'(cmag_r[k][CMAG_W-1:8]);
        low_r[0][k] <= {cmag_r[k][7:0], {(LOW_W-8){1'b0}}};
        quo_r[0][k] <= '0;
        neg_r[0][k] <= csgn_r[k] ^ dsgn6_r;
      end
      dmag_r[0] <= dmag6_r;
      sing_r[0] <= dzero6_r;
    end
  end

  // restoring divider, one quotient bit per stage in each lane
  for (genvar s = 0; s < QBITS; s++) begin : g_div
    always_ff @(posedge clk) begin
      logic [DET_W:0] rem2;
      if (ce) begin
        for (int k = 0; k < NENT; k++) begin
          rem2 = {rem_r[s][k], low_r[s][k][LOW_W-1]};
          if (rem2 >= {1'b0, dmag_r[s]}) begin
            rem_r[s+1][k] <= dmag_t'(rem2 - {1'b0, dmag_r[s]});
            quo_r[s+1][k] <= {quo_r[s][k][QBITS-2:0], 1'b1};
          end else begin
            rem_r[s+1][k] <= dmag_t'(rem2);
            quo_r[s+1][k] <= {quo_r[s][k][QBITS-2:0], 1'b0};
          end
          low_r[s+1][k] <= {low_r[s][k][LOW_W-2:0], 1'b0};
          ovf_r[s+1][k] <= ovf_r[s][k];
          neg_r[s+1][k] <= neg_r[s][k];
        end
        dmag_r[s+1] <= dmag_r[s];
        sing_r[s+1] <= sing_r[s];
      end
    end
  end

  // output stage: sign, saturation, singular zeroing
  always_ff @(posedge clk) begin
    logic [OUT_W-1:0] q;
    logic             ov;
    if (ce) begin
      for (int k = 0; k < NENT; k++) begin
        q  = quo_r[QBITS][k];
        ov = ovf_r[QBITS][k];
        if (sing_r[QBITS]) begin
          odata_r[OUT_W*k +: OUT_W] <= '0;
        end else if (neg_r[QBITS][k]) begin
          if (ov || q > SAT_NEG) odata_r[OUT_W*k +: OUT_W] <= SAT_NEG;
          else odata_r[OUT_W*k +: OUT_W] <= -q;
        end else begin
          if (ov || q[OUT_W-1]) odata_r[OUT_W*k +: OUT_W] <= SAT_POS;
          else odata_r[OUT_W*k +: OUT_W] <= q;
        end
      end
      osing_r <= sing_r[QBITS];
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = osing_r;

  // checks
  `AST_IMPLIES(a_sing_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == '0)
  `AST_NEXT(a_enter, clk, rst_n, in_tvalid && in_tready, v1_r)
  `AST_IMPLIES(a_zero_det_ovf, clk, rst_n, v7_r && sing_r[0], ovf_r[0][0] && ovf_r[0][8])

endmodule

// ===== tb/sv/matrix3x3_inverse_tb.sv =====
// testbench for the 3x3 matrix inverse pipeline: random and directed matrices, back-pressure and no-idle runs
module matrix3x3_inverse_tb;
  import mi3_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] e8, e7, e6, e5, e4, e3, e2, e1, e0;
    logic             sing;
  } inv_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [287:0] out_tdata;
  logic [0:0]   out_tuser;

  inv_res_t inverse_q[$];
  int       n_errors = 0;
  bit       calm_mode = 0;   // no idling on either side
  int       hold_cycles = 0; // long receiver hold-off

  matrix3x3_inverse i_dut (.*);

  always #5 clk = ~clk;

  // truncating divide of cofactor by determinant, saturated to 32 bits
  function automatic logic [OUT_W-1:0] sat_quot(longint cof, longint det);
    longint q;
    q = (cof * 64'sd16777216) / det;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[OUT_W-1:0];
  endfunction

  // expected inverse of one matrix
  function automatic inv_res_t adjugate_inverse(logic [143:0] d);
    longint m[9];
    longint c[9];
    longint det;
    logic [OUT_W-1:0] q[9];
    inv_res_t r;
    for (int k = 0; k < 9; k++) m[k] = longint'($signed(d[k*16 +: 16]));
    c[0] = m[4]*m[8] - m[5]*m[7];
    c[1] = m[7]*m[2] - m[8]*m[1];
    c[2] = m[1]*m[5] - m[2]*m[4];
    c[3] = m[5]*m[6] - m[3]*m[8];
    c[4] = m[8]*m[0] - m[6]*m[2];
    c[5] = m[2]*m[3] - m[0]*m[5];
    c[6] = m[3]*m[7] - m[4]*m[6];
    c[7] = m[6]*m[1] - m[7]*m[0];
    c[8] = m[0]*m[4] - m[1]*m[3];
    det = m[0]*c[0] + m[1]*c[3] + m[2]*c[6];
    for (int k = 0; k < 9; k++) q[k] = (det == 0) ? '0 : sat_quot(c[k], det);
    r = {q[8], q[7], q[6], q[5], q[4], q[3], q[2], q[1], q[0], det == 0};
    return r;
  endfunction

  // send one matrix, wait for acceptance; valid drops only while idling
  task automatic send_matrix(logic [143:0] d);
    while (!calm_mode && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    inverse_q.push_back(adjugate_inverse(d));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [143:0] pack9(int v[9]);
    logic [143:0] d;
    for (int k = 0; k < 9; k++) d[k*16 +: 16] = v[k][15:0];
    return d;
  endfunction

  // receiver readiness
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= calm_mode || ($urandom_range(99) >= 30);
    end
  end

  // result checker
  always @(posedge clk) begin
    inv_res_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser[0]};
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected item: got %h", $time, got);
        n_errors++;
      end else begin
        exp_r = inverse_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[1 + k*32 +: 32] != exp_r[1 + k*32 +: 32]) begin
            $display("%0t: inv entry %0d mismatch: expected %h actual %h", $time, k,
                     exp_r[1 + k*32 +: 32], got[1 + k*32 +: 32]);
            n_errors++;
          end
        if (got.sing != exp_r.sing) begin
          $display("%0t: singular mismatch: expected %b actual %b", $time,
                   exp_r.sing, got.sing);
          n_errors++;
        end
      end
    end
  end

  // extremes, identity, singular and saturating cases
  task automatic test_directed();
    int v[9];
    int ext[4] = '{-32768, 32767, 0, -1};
    v = '{256, 0, 0, 0, 256, 0, 0, 0, 256}; send_matrix(pack9(v));
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(pack9(v));
    v = '{1, 2, 3, 2, 4, 6, 7, 8, 9}; send_matrix(pack9(v));
    v = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(pack9(v));
    v = '{-1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(pack9(v));
    v = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767}; send_matrix(pack9(v));
    v = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; send_matrix(pack9(v));
    v = '{-32768, 32767, 0, 32767, -32768, 0, 0, 0, 1}; send_matrix(pack9(v));
    v = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    send_matrix(pack9(v));
    v = '{0, 256, 0, 256, 0, 0, 0, 0, 256}; send_matrix(pack9(v));
    v = '{512, -256, 3, 77, -900, 128, -5, 4000, 256}; send_matrix(pack9(v));
    for (int n = 0; n < 12; n++) begin
      for (int k = 0; k < 9; k++) v[k] = ext[$urandom_range(3)];
      send_matrix(pack9(v));
    end
  endtask

  // random matrices: full range, small entries, medium entries, singular by row copy
  task automatic test_random(int count);
    int v[9];
    int s;
    for (int n = 0; n < count; n++) begin
      s = $urandom_range(3);
      for (int k = 0; k < 9; k++)
        case (s)
          0: v[k] = int'($urandom_range(65535)) - 32768;
          1: v[k] = int'($urandom_range(8)) - 4;
          2: v[k] = int'($urandom_range(1024)) - 512;
          default: v[k] = int'($urandom_range(65535)) - 32768;
        endcase
      // make row 2 a copy of row 0 for singular cases
      if (s == 3 && $urandom_range(1)) begin
        v[6] = v[0]; v[7] = v[1]; v[8] = v[2];
      end
      send_matrix(pack9(v));
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    calm_mode = 1;
    in_tvalid <= 1'b0;
    @(posedge clk);
    hold_cycles <= 150;
    test_random(120);
    calm_mode = 0;
  endtask

  task automatic test_no_idle();
    calm_mode = 1;
    test_random(300);
    calm_mode = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_backpressure();
    test_no_idle();
    test_random(560);
    in_tvalid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
